[design/two_opt_best_improvement_core_macros.svh]
// Assertion macros used by the checker file of the 2-opt core.
`ifndef TWO_OPT_BEST_IMPROVEMENT_CORE_MACROS_SVH
`define TWO_OPT_BEST_IMPROVEMENT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TOB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TOB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tob_pkg.sv]
// Shared types and constants of the 2-opt core.
package tob_pkg;

  localparam int TOB_MAX_CITIES = 1024;
  localparam int KIND_W         = 2;
  localparam int IDX_W          = 10;
  localparam int CRD_W          = 16;
  localparam int CITY_W         = 10;
  localparam int VAL_W          = 32;
  localparam int NC_W           = 11;
  localparam int DIST_W         = 25;
  localparam int GAIN_W         = 26;
  localparam int RAD_W          = 50;
  localparam int REM_W          = 27;
  localparam int SQ_STEPS       = 25;
  localparam int QDEPTH         = 4;
  localparam int QAW            = $clog2(QDEPTH);
  localparam int QCW            = $clog2(QDEPTH + 1);

  localparam logic [NC_W-1:0] NC_RESET = NC_W'(4);

  localparam logic RES_PASSES = 1'b0;
  localparam logic RES_TOUR   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LD_XY   = 2'd0,
    KIND_LD_TOUR = 2'd1,
    KIND_RUN     = 2'd2,
    KIND_RD      = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  index;
    logic [CRD_W-1:0]  coord_x;
    logic [CRD_W-1:0]  coord_y;
    logic              in_range;
  } tob_entry_t;

  typedef struct packed {
    logic       push;
    tob_entry_t entry;
  } tob_qpush_t;

  typedef struct packed {
    logic       avail;
    tob_entry_t entry;
  } tob_qhead_t;

endpackage

[design/tob_cmd_if.sv]
// Command channel interface: one word per load, run or read request.
interface tob_cmd_if import tob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  index;
  logic [CRD_W-1:0]  coord_x;
  logic [CRD_W-1:0]  coord_y;

  modport source (output valid, kind, index, coord_x, coord_y, input ready);
  modport sink   (input valid, kind, index, coord_x, coord_y, output ready);
endinterface

[design/tob_res_if.sv]
// Result channel interface: pass count or tour entry.
interface tob_res_if import tob_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [VAL_W-1:0] value;

  modport source (output valid, result_kind, value, input ready);
  modport sink   (input valid, result_kind, value, output ready);
endinterface

[design/two_opt_best_improvement_core.sv]
// Top level of the best-improvement 2-opt search core.
//
//   channel  | dir | word
//   ---------+-----+----------------------------------------------
//   in_chan  | in  | kind, index, coord_x, coord_y
//   out_chan | out | result_kind, value
//   cfg_*    | in  | num_cities, written when cfg_wr_en is high
//
// Loads are written as they leave the queue; a tour read passes through ST_RD
// to the output register. A run's time per pass is set by the shared distance
// unit with its 25-step bit-serial square root, used for each (i, j) pair, and
// by the swap states per exchanged pair of entries. During a run the queue still
// takes up to four words, then the input stalls until the run ends.
// Reset clears control state only; memory contents stay undefined until loaded.
// A four-deep queue parts the input side from the back end; the output
// register holds a result until it is taken.
module two_opt_best_improvement_core import tob_pkg::*; #(
  parameter int MAX_CITIES = TOB_MAX_CITIES
) (
  input  logic            clk,
  input  logic            rst_n,
  tob_cmd_if.sink         in_chan,
  tob_res_if.source       out_chan,
  input  logic            cfg_wr_en,
  input  logic [NC_W-1:0] cfg_wr_data
);

  logic [NC_W-1:0] num_cities_r;
  tob_qpush_t      q_push;
  tob_qhead_t      q_head;
  logic            q_full;
  logic            q_pop;

  // Hold the city count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= NC_RESET;
    end else if (cfg_wr_en) begin
      num_cities_r <= cfg_wr_data;
    end
  end

  tob_front #(.MAX_CITIES(MAX_CITIES)) u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  tob_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  tob_back #(.MAX_CITIES(MAX_CITIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .num_cities (num_cities_r),
    .out_chan   (out_chan)
  );

endmodule

[design/tob_front.sv]
// Front end: takes command words, checks the index range and queues all but out-of-range loads.
module tob_front import tob_pkg::*; #(
  parameter int MAX_CITIES = TOB_MAX_CITIES
) (
  tob_cmd_if.sink    in_chan,
  input  logic       q_full,
  output tob_qpush_t q_push
);

  localparam int unsigned MaxC = MAX_CITIES;

  kind_t kind;
  logic  in_range;
  logic  drop;

  // Classify the word; drop loads that fall outside the memories
  always_comb begin
    kind     = kind_t'(in_chan.kind);
    in_range = (32'(in_chan.index) < MaxC);
    drop     = (kind inside {KIND_LD_XY, KIND_LD_TOUR}) && !in_range;
  end

  assign in_chan.ready = !q_full;

  always_comb begin
    q_push.push           = in_chan.valid && !q_full && !drop;
    q_push.entry.kind     = kind;
    q_push.entry.index    = in_chan.index;
    q_push.entry.coord_x  = in_chan.coord_x;
    q_push.entry.coord_y  = in_chan.coord_y;
    q_push.entry.in_range = in_range;
  end

endmodule

[design/tob_fifo.sv]
// Short command queue between front end and back end.
module tob_fifo import tob_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tob_qpush_t q_push,
  output logic       q_full,
  input  logic       q_pop,
  output tob_qhead_t q_head
);

  tob_entry_t         slot_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QCW-1:0]     count_r;
  logic               do_push;
  logic               do_pop;

  assign q_full       = (count_r == QCW'(QDEPTH));
  assign do_push      = q_push.push && !q_full;
  assign do_pop       = q_pop && (count_r != '0);
  assign q_head.avail = (count_r != '0);
  assign q_head.entry = slot_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

endmodule

[design/tob_dist.sv]
// Distance unit: abs, squares, then a bit-serial integer square root.
module tob_dist import tob_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAL_W-1:0]  coord_a,
  input  logic [VAL_W-1:0]  coord_b,
  output logic              busy,
  output logic              done,
  output logic [DIST_W-1:0] d_out
);

  localparam int SW = $clog2(SQ_STEPS + 1);

  logic                 v1_r, v2_r, sq_busy_r, done_r;
  logic [SW-1:0]        step_r;
  logic [CRD_W-1:0]     dx_r, dy_r;
  logic [2*CRD_W-1:0]   sqx_r, sqy_r;
  logic [RAD_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [DIST_W-1:0]    root_r;
  logic                 go;
  logic [CRD_W-1:0]     xa, ya, xb, yb;
  logic [2*CRD_W:0]     sum;
  logic [REM_W+1:0]     cur, trial;

  assign busy  = v1_r || v2_r || sq_busy_r;
  assign go    = start && !busy;
  assign done  = done_r;
  assign d_out = root_r;

  always_comb begin
    xa    = coord_a[CRD_W-1:0];
    ya    = coord_a[VAL_W-1:CRD_W];
    xb    = coord_b[CRD_W-1:0];
    yb    = coord_b[VAL_W-1:CRD_W];
    sum   = (2*CRD_W+1)'(sqx_r) + (2*CRD_W+1)'(sqy_r);
    cur   = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial = {2'b00, root_r, 2'b01};
  end

  // Sequence the stages and count root steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      sq_busy_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      done_r <= 1'b0;
      v1_r   <= go;
      v2_r   <= v1_r;
      if (v2_r) begin
        sq_busy_r <= 1'b1;
        step_r    <= SW'(SQ_STEPS);
      end else if (sq_busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          sq_busy_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  // Datapath: differences, squares, then one root bit a cycle
  always_ff @(posedge clk) begin
    if (go) begin
      dx_r <= (xa > xb) ? (xa - xb) : (xb - xa);
      dy_r <= (ya > yb) ? (ya - yb) : (yb - ya);
    end
    if (v1_r) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
    if (v2_r) begin
      rad_r  <= {1'b0, sum, 16'b0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (sq_busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_r  <= REM_W'(cur - trial);
        root_r <= {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(cur);
        root_r <= {root_r[DIST_W-2:0], 1'b0};
      end
    end
  end

endmodule

[design/tob_back.sv]
// Back end: memories, load/read handling and the 2-opt search sequencer.
module tob_back import tob_pkg::*; #(
  parameter int MAX_CITIES = TOB_MAX_CITIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tob_qhead_t      q_head,
  output logic            q_pop,
  input  logic [NC_W-1:0] num_cities,
  tob_res_if.source       out_chan
);

  localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int unsigned MaxC = MAX_CITIES;

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_RD    = 19'h00002,
    ST_PASS  = 19'h00004,
    ST_I_RD  = 19'h00008,
    ST_I_CRD = 19'h00010,
    ST_I_CW  = 19'h00020,
    ST_I_DW  = 19'h00040,
    ST_J_RD  = 19'h00080,
    ST_J_CRD = 19'h00100,
    ST_J_CW  = 19'h00200,
    ST_D1    = 19'h00400,
    ST_D2    = 19'h00800,
    ST_D3    = 19'h01000,
    ST_CMP   = 19'h02000,
    ST_END   = 19'h04000,
    ST_SW_RD = 19'h08000,
    ST_SW_W1 = 19'h10000,
    ST_SW_W2 = 19'h20000,
    ST_DONE  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  logic [CITY_W-1:0] tour_mem  [MAX_CITIES];
  logic [VAL_W-1:0]  coord_mem [MAX_CITIES];

  logic [CITY_W-1:0] trd_a_r, trd_b_r, tmp_r;
  logic [VAL_W-1:0]  crd_a_r, crd_b_r;
  logic              cok_a_r, cok_b_r;
  logic [VAL_W-1:0]  ci_r, ci1_r, cj_r, cj1_r;
  logic [NW-1:0]     n_r, i_r, j_r, lo_r, hi_r, bi_r, bj_r;
  logic [DIST_W-1:0] di_r;
  logic [GAIN_W-1:0] f_r, s_r, best_r;
  logic [VAL_W-1:0]  passes_r;
  logic              rd_ok_r;
  logic              out_valid_r, out_kind_r;
  logic [VAL_W-1:0]  out_value_r;

  tob_entry_t        e;
  logic              take;
  logic [AW-1:0]     tra, trb, tw_addr, cw_addr;
  logic              tw_en, cw_en;
  logic [CITY_W-1:0] tw_data;
  logic [VAL_W-1:0]  coord_a, coord_b, dist_a, dist_b;
  logic              dist_go, dist_busy, dist_done;
  logic [DIST_W-1:0] dist_val;
  logic [31:0]       nc_clamp;
  logic              gain_up, j_more, i_more, pairs;

  tob_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_go),
    .coord_a (dist_a),
    .coord_b (dist_b),
    .busy    (dist_busy),
    .done    (dist_done),
    .d_out   (dist_val)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.value       = out_value_r;

  // Decode the queue head; results wait for a free output register
  always_comb begin
    e    = q_head.entry;
    take = (state_r == ST_IDLE) && q_head.avail &&
           ((e.kind inside {KIND_LD_XY, KIND_LD_TOUR}) || !out_valid_r);
    q_pop = take;
  end

  // Clamp the city count and form loop tests
  always_comb begin
    if (32'(num_cities) < 32'd4) begin
      nc_clamp = 32'd4;
    end else if (32'(num_cities) > MaxC) begin
      nc_clamp = MaxC;
    end else begin
      nc_clamp = 32'(num_cities);
    end
    coord_a = cok_a_r ? crd_a_r : '0;
    coord_b = cok_b_r ? crd_b_r : '0;
    pairs   = (NW+1)'(n_r) > (NW+1)'(4);
    j_more  = ((NW+1)'(j_r) + (NW+1)'(3)) < (NW+1)'(n_r);
    i_more  = ((NW+1)'(i_r) + (NW+1)'(5)) < (NW+1)'(n_r);
    gain_up = (f_r > s_r) && ((f_r - s_r) > best_r);
  end

  // Next state, memory ports and distance requests
  always_comb begin
    state_nxt = state_r;
    tra       = '0;
    trb       = '0;
    tw_en     = 1'b0;
    tw_addr   = AW'(e.index);
    tw_data   = e.coord_x[CITY_W-1:0];
    cw_en     = take && (e.kind == KIND_LD_XY);
    cw_addr   = AW'(e.index);
    dist_go   = 1'b0;
    dist_a    = ci_r;
    dist_b    = cj_r;
    case (state_r)
      ST_IDLE: begin
        tra = AW'(e.index);
        if (take) begin
          case (e.kind)
            KIND_LD_TOUR: tw_en = 1'b1;
            KIND_RUN:     state_nxt = ST_PASS;
            KIND_RD:      state_nxt = ST_RD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:    state_nxt = ST_IDLE;
      ST_PASS:  state_nxt = pairs ? ST_I_RD : ST_DONE;
      ST_I_RD: begin
        tra       = AW'(i_r);
        trb       = AW'(i_r + NW'(1));
        state_nxt = ST_I_CRD;
      end
      ST_I_CRD: state_nxt = ST_I_CW;
      ST_I_CW: begin
        dist_go   = 1'b1;
        dist_a    = coord_a;
        dist_b    = coord_b;
        state_nxt = ST_I_DW;
      end
      ST_I_DW:  state_nxt = dist_done ? ST_J_RD : ST_I_DW;
      ST_J_RD: begin
        tra       = AW'(j_r);
        trb       = AW'(j_r + NW'(1));
        state_nxt = ST_J_CRD;
      end
      ST_J_CRD: state_nxt = ST_J_CW;
      ST_J_CW: begin
        dist_go   = 1'b1;
        dist_a    = coord_a;
        dist_b    = coord_b;
        state_nxt = ST_D1;
      end
      ST_D1: begin
        if (dist_done) begin
          dist_go   = 1'b1;
          state_nxt = ST_D2;
        end
      end
      ST_D2: begin
        dist_a = ci1_r;
        dist_b = cj1_r;
        if (dist_done) begin
          dist_go   = 1'b1;
          state_nxt = ST_D3;
        end
      end
      ST_D3:    state_nxt = dist_done ? ST_CMP : ST_D3;
      ST_CMP: begin
        if (j_more) begin
          state_nxt = ST_J_RD;
        end else if (i_more) begin
          state_nxt = ST_I_RD;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END:   state_nxt = (best_r != '0) ? ST_SW_RD : ST_DONE;
      ST_SW_RD: begin
        tra       = AW'(lo_r);
        trb       = AW'(hi_r);
        state_nxt = (lo_r < hi_r) ? ST_SW_W1 : ST_PASS;
      end
      ST_SW_W1: begin
        tw_en     = 1'b1;
        tw_addr   = AW'(lo_r);
        tw_data   = trd_b_r;
        state_nxt = ST_SW_W2;
      end
      ST_SW_W2: begin
        tw_en     = 1'b1;
        tw_addr   = AW'(hi_r);
        tw_data   = tmp_r;
        state_nxt = ST_SW_RD;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memories: one write port each, two registered read ports each
  always_ff @(posedge clk) begin
    if (tw_en) begin
      tour_mem[tw_addr] <= tw_data;
    end
    if (cw_en) begin
      coord_mem[cw_addr] <= {e.coord_y, e.coord_x};
    end
    trd_a_r <= tour_mem[tra];
    trd_b_r <= tour_mem[trb];
    crd_a_r <= coord_mem[AW'(trd_a_r)];
    crd_b_r <= coord_mem[AW'(trd_b_r)];
    cok_a_r <= (32'(trd_a_r) < MaxC);
    cok_b_r <= (32'(trd_b_r) < MaxC);
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_RD || state_r == ST_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Search registers and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          rd_ok_r  <= e.in_range;
          n_r      <= NW'(nc_clamp);
          passes_r <= '0;
        end
      end
      ST_RD: begin
        out_kind_r  <= RES_TOUR;
        out_value_r <= rd_ok_r ? VAL_W'(trd_a_r) : '0;
      end
      ST_PASS: begin
        if (passes_r != '1) begin
          passes_r <= passes_r + VAL_W'(1);
        end
        best_r <= '0;
        bi_r   <= '0;
        bj_r   <= '0;
        i_r    <= '0;
      end
      ST_I_CW: begin
        ci_r  <= coord_a;
        ci1_r <= coord_b;
        j_r   <= i_r + NW'(2);
      end
      ST_I_DW: begin
        if (dist_done) begin
          di_r <= dist_val;
        end
      end
      ST_J_CW: begin
        cj_r  <= coord_a;
        cj1_r <= coord_b;
      end
      ST_D1: begin
        if (dist_done) begin
          f_r <= GAIN_W'(di_r) + GAIN_W'(dist_val);
        end
      end
      ST_D2: begin
        if (dist_done) begin
          s_r <= GAIN_W'(dist_val);
        end
      end
      ST_D3: begin
        if (dist_done) begin
          s_r <= s_r + GAIN_W'(dist_val);
        end
      end
      ST_CMP: begin
        if (gain_up) begin
          best_r <= f_r - s_r;
          bi_r   <= i_r;
          bj_r   <= j_r;
        end
        if (j_more) begin
          j_r <= j_r + NW'(1);
        end else begin
          i_r <= i_r + NW'(1);
        end
      end
      ST_END: begin
        lo_r <= bi_r + NW'(1);
        hi_r <= bj_r;
      end
      ST_SW_W1: tmp_r <= trd_a_r;
      ST_SW_W2: begin
        lo_r <= lo_r + NW'(1);
        hi_r <= hi_r - NW'(1);
      end
      ST_DONE: begin
        out_kind_r  <= RES_PASSES;
        out_value_r <= passes_r;
      end
      default: tmp_r <= tmp_r;
    endcase
  end

endmodule

[design/tob_checker.sv]
// Port checker of the 2-opt core, bound to the top level.
`include "two_opt_best_improvement_core_macros.svh"

module tob_checker import tob_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_result_kind,
  input logic [VAL_W-1:0] out_value
);

  `TOB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `TOB_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_value) && $stable(out_result_kind), "stalled result word changed")
  `TOB_ASSERT_IMP(a_tour_width, out_valid && (out_result_kind == RES_TOUR), out_value[VAL_W-1:CITY_W] == '0, "tour entry wider than a city number")
  `TOB_ASSERT_IMP(a_pass_nonzero, out_valid && (out_result_kind == RES_PASSES), out_value != '0, "run reported zero passes")

endmodule

bind two_opt_best_improvement_core tob_checker u_tob_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_result_kind (out_chan.result_kind),
  .out_value       (out_chan.value)
);
